### rtl/bcd_rtc_to_epoch_seconds_defines.svh
// ----------------------------------------------------------------------------
// rtc epoch converter assertion macros
// shared property macros for the port checker
// ----------------------------------------------------------------------------
`ifndef BCD_RTC_TO_EPOCH_SECONDS_DEFINES_SVH
`define BCD_RTC_TO_EPOCH_SECONDS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RTCEP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtcep same-cycle check failed");

// antecedent implies consequent in the next cycle
`define RTCEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcep next-cycle check failed");

`endif

### rtl/rtcep_pkg.sv
// ----------------------------------------------------------------------------
// rtcep_pkg
// types, constants and helpers for the rtc snapshot to epoch converter
// ----------------------------------------------------------------------------
package rtcep_pkg;

    localparam logic [7:0]  STATUS_ABSENT_HI = 8'hFF;
    localparam logic [7:0]  STATUS_ABSENT_LO = 8'h00;
    localparam logic [7:0]  YEAR_PIVOT       = 8'd70;
    localparam logic [7:0]  CENTURY          = 8'd100;
    localparam logic [3:0]  MONTH_LIMIT      = 4'd13;
    localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
    localparam logic [31:0] SECS_PER_MIN     = 32'd60;
    localparam logic [14:0] MINS_PER_HOUR    = 15'd60;
    localparam logic [15:0] DAYS_PER_YEAR    = 16'd365;
    // leap years counted below 1970, i.e. floor(69 / 4)
    localparam logic [5:0]  LEAPS_BEFORE     = 6'd17;

    // configuration register indexes
    localparam logic CFG_UTC_MODE    = 1'b0;
    localparam logic CFG_ZONE_OFFSET = 1'b1;

    typedef struct packed {
        logic              utc_mode;
        logic signed [10:0] zone_offset_minutes;
    } rtcep_cfg_t;

    // decoded snapshot between decode and scaling
    typedef struct packed {
        logic signed [16:0] days;
        logic signed [14:0] minutes;
        logic [7:0]         secs;
        logic               missing;
    } rtcep_mid_t;

    // high nibble times ten plus low nibble, no digit check
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // days in the months before month m (m already clipped to 0..13)
    function automatic logic [8:0] month_cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            default: d = 9'd0;
        endcase
        if (leap && (m >= 4'd3))
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

### rtl/rtcep_cfg.sv
// ----------------------------------------------------------------------------
// rtcep_cfg
// configuration registers: utc mode and time zone offset
// ----------------------------------------------------------------------------
module rtcep_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [10:0]          cfg_data,
    output rtcep_pkg::rtcep_cfg_t cfg
);
    import rtcep_pkg::*;

    logic               utc_mode_reg;
    logic signed [10:0] zone_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utc_mode_reg <= 1'b0;
            zone_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_UTC_MODE:    utc_mode_reg <= cfg_data[0];
                CFG_ZONE_OFFSET: zone_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.utc_mode            = utc_mode_reg;
    assign cfg.zone_offset_minutes = zone_reg;

endmodule

### rtl/rtcep_decode.sv
// ----------------------------------------------------------------------------
// rtcep_decode
// bcd decode, closed-form day count and minute count with zone correction
// ----------------------------------------------------------------------------
module rtcep_decode (
    input  logic [7:0]            status_a_byte,
    input  logic [7:0]            year_bcd,
    input  logic [7:0]            month_bcd,
    input  logic [7:0]            day_bcd,
    input  logic [7:0]            hour_bcd,
    input  logic [7:0]            minute_bcd,
    input  logic [7:0]            sec_bcd,
    input  rtcep_pkg::rtcep_cfg_t cfg,
    output rtcep_pkg::rtcep_mid_t mid
);
    import rtcep_pkg::*;

    logic [7:0]         year_dec;
    logic [7:0]         year_adj;
    logic [7:0]         year_m1;
    logic [7:0]         years_since;
    logic [5:0]         leaps;
    logic               leap;
    logic [15:0]        year_days;
    logic [7:0]         month_dec;
    logic [3:0]         month_clip;
    logic [8:0]         month_days;
    logic [7:0]         day_dec;
    logic [7:0]         hour_dec;
    logic [7:0]         minute_dec;
    logic signed [10:0] tz;

    always_comb
    begin
        year_dec    = bcd_decode(year_bcd);
        // leap test on the two-digit value, same as after the century fix
        leap        = (year_dec[1:0] == 2'b00);
        year_adj    = (year_dec < YEAR_PIVOT) ? year_dec + CENTURY : year_dec;
        years_since = year_adj - YEAR_PIVOT;
        year_m1     = year_adj - 8'd1;
        leaps       = year_m1[7:2] - LEAPS_BEFORE;
        year_days   = 16'(years_since) * DAYS_PER_YEAR + 16'(leaps);

        month_dec   = bcd_decode(month_bcd);
        month_clip  = (month_dec > 8'(MONTH_LIMIT)) ? MONTH_LIMIT : month_dec[3:0];
        month_days  = month_cum_days(month_clip, leap);

        day_dec     = bcd_decode(day_bcd);
        hour_dec    = bcd_decode(hour_bcd);
        minute_dec  = bcd_decode(minute_bcd);
        tz          = cfg.utc_mode ? 11'sd0 : cfg.zone_offset_minutes;

        // day zero gives minus one day here, wrapped later
        mid.days    = signed'(17'(year_days) + 17'(month_days) + 17'(day_dec) - 17'd1);
        mid.minutes = signed'(15'(hour_dec) * MINS_PER_HOUR + 15'(minute_dec)
                              - {{4{tz[10]}}, tz});
        mid.secs    = bcd_decode(sec_bcd);
        mid.missing = (status_a_byte == STATUS_ABSENT_HI) ||
                      (status_a_byte == STATUS_ABSENT_LO);
    end

endmodule

### rtl/rtcep_scale.sv
// ----------------------------------------------------------------------------
// rtcep_scale
// scales days and minutes to seconds, sums modulo 2^32; zero if clock missing
// ----------------------------------------------------------------------------
module rtcep_scale (
    input  rtcep_pkg::rtcep_mid_t mid,
    output logic [31:0]           epoch_next
);
    import rtcep_pkg::*;

    logic [31:0] days_ext;
    logic [31:0] mins_ext;
    logic [31:0] total;

    always_comb
    begin
        days_ext   = {{15{mid.days[16]}}, mid.days};
        mins_ext   = {{17{mid.minutes[14]}}, mid.minutes};
        total      = days_ext * SECS_PER_DAY + mins_ext * SECS_PER_MIN + 32'(mid.secs);
        epoch_next = mid.missing ? 32'd0 : total;
    end

endmodule

### rtl/bcd_rtc_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// bcd_rtc_to_epoch_seconds
// pc rtc bcd snapshot to seconds since 1970, three register pipeline
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid / in_stall carry one rtc snapshot word (status
//   byte plus bcd year, month, day, hour, minute, second). a word is taken
//   at a clock edge with in_valid high and in_stall low.
//   output channel: out_valid / out_stall carry epoch_seconds and
//   clock_missing; the receiver holds out_stall high to wait.
//   config channel: cfg_valid / cfg_ready, cfg_index 0 = utc mode,
//   1 = zone offset in minutes (11-bit signed). cfg_ready is always high.
// path: a taken word passes the decode and result registers to out_valid.
// throughput: one word per cycle while the output is not stalled; set by the
//   input, decode and result registers, each moving unless held by a stall.
// stall: back-pressure passes back combinationally; in_stall goes high
//   only when all three registers hold words and out_stall is high.
// reset: rst_n clears all valid flags and the config registers
//   (utc mode off, zero offset).
// ----------------------------------------------------------------------------
module bcd_rtc_to_epoch_seconds (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  status_a_byte,
    input  logic [7:0]  year_bcd,
    input  logic [7:0]  month_bcd,
    input  logic [7:0]  day_bcd,
    input  logic [7:0]  hour_bcd,
    input  logic [7:0]  minute_bcd,
    input  logic [7:0]  sec_bcd,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] epoch_seconds,
    output logic        clock_missing,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);
    import rtcep_pkg::*;

    rtcep_cfg_t  cfg;
    rtcep_mid_t  mid_next;
    rtcep_mid_t  mid_reg;
    logic [31:0] epoch_next;

    logic        in_vld_reg;
    logic        mid_vld_reg;
    logic        out_vld_reg;
    logic [7:0]  status_reg;
    logic [7:0]  year_reg;
    logic [7:0]  month_reg;
    logic [7:0]  day_reg;
    logic [7:0]  hour_reg;
    logic [7:0]  minute_reg;
    logic [7:0]  sec_reg;
    logic [31:0] epoch_reg;
    logic        missing_reg;

    logic        out_open;
    logic        mid_open;
    logic        in_open;

    rtcep_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtcep_decode u_decode (
        .status_a_byte (status_reg),
        .year_bcd      (year_reg),
        .month_bcd     (month_reg),
        .day_bcd       (day_reg),
        .hour_bcd      (hour_reg),
        .minute_bcd    (minute_reg),
        .sec_bcd       (sec_reg),
        .cfg           (cfg),
        .mid           (mid_next)
    );

    rtcep_scale u_scale (
        .mid        (mid_reg),
        .epoch_next (epoch_next)
    );

    // a stage can load when it is empty or its word moves on this cycle
    assign out_open = !out_vld_reg || !out_stall;
    assign mid_open = !mid_vld_reg || out_open;
    assign in_open  = !in_vld_reg || mid_open;
    assign in_stall = !in_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_open)
            begin
                in_vld_reg <= in_valid;
            end
            if (mid_open)
            begin
                mid_vld_reg <= in_vld_reg;
            end
            if (out_open)
            begin
                out_vld_reg <= mid_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_open && in_valid)
        begin
            status_reg <= status_a_byte;
            year_reg   <= year_bcd;
            month_reg  <= month_bcd;
            day_reg    <= day_bcd;
            hour_reg   <= hour_bcd;
            minute_reg <= minute_bcd;
            sec_reg    <= sec_bcd;
        end
        if (mid_open && in_vld_reg)
        begin
            mid_reg <= mid_next;
        end
        if (out_open && mid_vld_reg)
        begin
            epoch_reg   <= epoch_next;
            missing_reg <= mid_reg.missing;
        end
    end

    assign out_valid     = out_vld_reg;
    assign epoch_seconds = epoch_reg;
    assign clock_missing = missing_reg;

endmodule

### rtl/rtcep_checker.sv
// ----------------------------------------------------------------------------
// rtcep_checker
// port-level checks for the rtc epoch converter, bound to the top level
// ----------------------------------------------------------------------------
`include "bcd_rtc_to_epoch_seconds_defines.svh"

module rtcep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  status_a_byte,
    input logic [7:0]  year_bcd,
    input logic [7:0]  month_bcd,
    input logic [7:0]  day_bcd,
    input logic [7:0]  hour_bcd,
    input logic [7:0]  minute_bcd,
    input logic [7:0]  sec_bcd,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] epoch_seconds,
    input logic        clock_missing,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // a held result word stays put
    `RTCEP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(epoch_seconds) && $stable(clock_missing))

    // an absent clock always reports zero seconds
    `RTCEP_ASSERT_SAME(a_missing_zero, clk, rst_n, out_valid && clock_missing,
        epoch_seconds == 32'd0)

    // with an empty output the pipeline can always take a word
    `RTCEP_ASSERT_SAME(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall)

    // a stalled input word stays put until it is taken
    `RTCEP_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(status_a_byte) && $stable(year_bcd) &&
        $stable(month_bcd) && $stable(day_bcd) && $stable(hour_bcd) &&
        $stable(minute_bcd) && $stable(sec_bcd))

    // config writes are never refused
    `RTCEP_ASSERT_SAME(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind bcd_rtc_to_epoch_seconds rtcep_checker u_rtcep_checker (.*);
